FILE: rtl/brss_pkg.sv
// Shared types, constants and helpers for the ball return strike sequencer.
// No dependencies; the other files use this package by scoped names or by import.
package brss_pkg;

   localparam int GateWidth   = 4;
   localparam int AngleWidth  = 16;
   localparam int SpeedWidth  = 16;
   localparam int StopWidth   = 15;
   localparam int DebWidth    = 4;
   localparam int SettleWidth = 10;
   localparam int AlignWidth  = 8;
   localparam int KindWidth   = 2;
   localparam int PhaseWidth  = 3;
   localparam int DefaultGateCount = 4;
   localparam int RegCount    = 8;
   localparam int AddrWidth   = 5;
   localparam int DataWidth   = 32;

   localparam logic [PhaseWidth-1:0] CODE_STARTUP = 3'd0;
   localparam logic [PhaseWidth-1:0] CODE_PLAN    = 3'd1;
   localparam logic [PhaseWidth-1:0] CODE_READY   = 3'd2;
   localparam logic [PhaseWidth-1:0] CODE_STRIKE  = 3'd3;
   localparam logic [PhaseWidth-1:0] CODE_BRAKE   = 3'd4;
   localparam logic [PhaseWidth-1:0] CODE_SETTLE  = 3'd5;
   localparam logic [PhaseWidth-1:0] CODE_ALIGN   = 3'd6;

   typedef enum logic [KindWidth-1:0] {
      KIND_NONE   = 2'd0,
      KIND_STRIKE = 2'd1,
      KIND_BRAKE  = 2'd2,
      KIND_HOME   = 2'd3
   } kind_type;

   typedef enum logic [6:0] {
      PH_STARTUP = 7'b0000001,
      PH_PLAN    = 7'b0000010,
      PH_READY   = 7'b0000100,
      PH_STRIKE  = 7'b0001000,
      PH_BRAKE   = 7'b0010000,
      PH_SETTLE  = 7'b0100000,
      PH_ALIGN   = 7'b1000000
   } phase_type;

   typedef enum logic [2:0] {
      REG_LEFT_LIMIT  = 3'd0,
      REG_RIGHT_LIMIT = 3'd1,
      REG_STOP_SPEED  = 3'd2,
      REG_DEBOUNCE    = 3'd3,
      REG_SETTLE      = 3'd4,
      REG_ALIGN       = 3'd5,
      REG_LEFT_HOME   = 3'd6,
      REG_RIGHT_HOME  = 3'd7
   } reg_index_type;

   typedef struct packed {
      logic signed [AngleWidth-1:0] left_limit;
      logic signed [AngleWidth-1:0] right_limit;
      logic [StopWidth-1:0]         stop_speed;
      logic [DebWidth-1:0]          debounce_ticks;
      logic [SettleWidth-1:0]       settle_ticks;
      logic [AlignWidth-1:0]        align_ticks;
   } cfg_type;

   typedef struct packed {
      phase_type                    phase;
      logic [DebWidth-1:0]          debounce_count;
      logic                         edge_armed;
      logic                         trigger_flag;
      logic                         serve_lock;
      logic signed [AngleWidth-1:0] captured_left;
      logic signed [AngleWidth-1:0] captured_right;
      logic [SettleWidth-1:0]       wait_count;
   } state_type;

   typedef struct packed {
      logic [GateWidth-1:0]         gate_bits;
      logic signed [AngleWidth-1:0] left_angle;
      logic signed [AngleWidth-1:0] right_angle;
      logic signed [SpeedWidth-1:0] left_speed;
      logic signed [SpeedWidth-1:0] right_speed;
   } item_type;

   typedef struct packed {
      kind_type                     command_kind;
      logic signed [AngleWidth-1:0] hold_left;
      logic signed [AngleWidth-1:0] hold_right;
      logic [PhaseWidth-1:0]        phase_now;
      logic                         trigger_seen;
   } result_type;

   function automatic logic [PhaseWidth-1:0] phase_code(input phase_type p);
      logic [PhaseWidth-1:0] c;
      case (p)
         PH_STARTUP: c = CODE_STARTUP;
         PH_PLAN:    c = CODE_PLAN;
         PH_READY:   c = CODE_READY;
         PH_STRIKE:  c = CODE_STRIKE;
         PH_BRAKE:   c = CODE_BRAKE;
         PH_SETTLE:  c = CODE_SETTLE;
         PH_ALIGN:   c = CODE_ALIGN;
         default:    c = CODE_READY;
      endcase
      return c;
   endfunction

endpackage

FILE: rtl/brss_if.sv
// Valid/ready channel interfaces for tick items and result items.
// Depends on brss_pkg for field widths.
interface brss_req_if;
   logic                                  valid;
   logic                                  ready;
   logic [brss_pkg::GateWidth-1:0]        gate_bits;
   logic signed [brss_pkg::AngleWidth-1:0] left_angle;
   logic signed [brss_pkg::AngleWidth-1:0] right_angle;
   logic signed [brss_pkg::SpeedWidth-1:0] left_speed;
   logic signed [brss_pkg::SpeedWidth-1:0] right_speed;

   modport source (output valid, gate_bits, left_angle, right_angle, left_speed,
                   right_speed, input ready);
   modport sink   (input valid, gate_bits, left_angle, right_angle, left_speed,
                   right_speed, output ready);
endinterface

interface brss_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic [brss_pkg::KindWidth-1:0]         command_kind;
   logic signed [brss_pkg::AngleWidth-1:0] hold_left;
   logic signed [brss_pkg::AngleWidth-1:0] hold_right;
   logic [brss_pkg::PhaseWidth-1:0]        phase_now;
   logic                                   trigger_seen;

   modport source (output valid, command_kind, hold_left, hold_right, phase_now,
                   trigger_seen, input ready);
   modport sink   (input valid, command_kind, hold_left, hold_right, phase_now,
                   trigger_seen, output ready);
endinterface

FILE: rtl/brss_csr.sv
// APB-style configuration register bank for the strike sequencer.
// Depends on brss_pkg for register indexes and the cfg_type bundle.
module brss_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [brss_pkg::AddrWidth-1:0]     paddr,
   input  logic [brss_pkg::DataWidth-1:0]     pwdata,
   output logic [brss_pkg::DataWidth-1:0]     prdata,
   output logic                               pready,
   output brss_pkg::cfg_type                  cfg
);
   brss_pkg::reg_index_type                       idx;
   logic                                          wr_en;
   logic signed [brss_pkg::AngleWidth-1:0]        left_limit_ff, right_limit_ff;
   logic [brss_pkg::StopWidth-1:0]                stop_speed_ff;
   logic [brss_pkg::DebWidth-1:0]                 debounce_ff;
   logic [brss_pkg::SettleWidth-1:0]              settle_ff;
   logic [brss_pkg::AlignWidth-1:0]               align_ff;
   logic signed [brss_pkg::AngleWidth-1:0]        left_home_ff, right_home_ff;

   assign pready = 1'b1;
   assign idx    = brss_pkg::reg_index_type'(paddr[brss_pkg::AddrWidth-1:2]);
   assign wr_en  = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         left_limit_ff  <= -16'sd1311;
         right_limit_ff <= 16'sd1393;
         stop_speed_ff  <= 15'd1024;
         debounce_ff    <= 4'd5;
         settle_ff      <= 10'd300;
         align_ff       <= 8'd40;
         left_home_ff   <= '0;
         right_home_ff  <= '0;
      end else if (wr_en) begin
         case (idx)
            brss_pkg::REG_LEFT_LIMIT:  left_limit_ff  <= pwdata[brss_pkg::AngleWidth-1:0];
            brss_pkg::REG_RIGHT_LIMIT: right_limit_ff <= pwdata[brss_pkg::AngleWidth-1:0];
            brss_pkg::REG_STOP_SPEED:  stop_speed_ff  <= pwdata[brss_pkg::StopWidth-1:0];
            brss_pkg::REG_DEBOUNCE:    debounce_ff    <= pwdata[brss_pkg::DebWidth-1:0];
            brss_pkg::REG_SETTLE:      settle_ff      <= pwdata[brss_pkg::SettleWidth-1:0];
            brss_pkg::REG_ALIGN:       align_ff       <= pwdata[brss_pkg::AlignWidth-1:0];
            brss_pkg::REG_LEFT_HOME:   left_home_ff   <= pwdata[brss_pkg::AngleWidth-1:0];
            brss_pkg::REG_RIGHT_HOME:  right_home_ff  <= pwdata[brss_pkg::AngleWidth-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (idx)
         brss_pkg::REG_LEFT_LIMIT:  prdata = 32'(left_limit_ff);
         brss_pkg::REG_RIGHT_LIMIT: prdata = 32'(right_limit_ff);
         brss_pkg::REG_STOP_SPEED:  prdata = {17'd0, stop_speed_ff};
         brss_pkg::REG_DEBOUNCE:    prdata = {28'd0, debounce_ff};
         brss_pkg::REG_SETTLE:      prdata = {22'd0, settle_ff};
         brss_pkg::REG_ALIGN:       prdata = {24'd0, align_ff};
         brss_pkg::REG_LEFT_HOME:   prdata = 32'(left_home_ff);
         brss_pkg::REG_RIGHT_HOME:  prdata = 32'(right_home_ff);
         default:                   prdata = '0;
      endcase
   end

   assign cfg.left_limit     = left_limit_ff;
   assign cfg.right_limit    = right_limit_ff;
   assign cfg.stop_speed     = stop_speed_ff;
   assign cfg.debounce_ticks = debounce_ff;
   assign cfg.settle_ticks   = settle_ff;
   assign cfg.align_ticks    = align_ff;
endmodule

FILE: rtl/brss_step.sv
// Per-tick next-state and result logic of the strike sequencer.
// Depends on brss_pkg for state, item, result and configuration types.
module brss_step #(
   parameter int GATE_COUNT = brss_pkg::DefaultGateCount
) (
   input  brss_pkg::state_type  state,
   input  brss_pkg::item_type   item,
   input  brss_pkg::cfg_type    cfg,
   output brss_pkg::state_type  state_next,
   output brss_pkg::result_type result
);
   logic [brss_pkg::GateWidth-1:0]   gate_mask;
   logic                             any;
   logic signed [brss_pkg::SpeedWidth:0] ls_ext, rs_ext;
   logic [brss_pkg::SpeedWidth:0]    ls_mag, rs_mag, stop_ext;
   logic [brss_pkg::SettleWidth-1:0] wait_inc;
   brss_pkg::kind_type               kind;
   brss_pkg::state_type              s;

   function automatic brss_pkg::state_type debounce(input brss_pkg::state_type d,
                                                    input logic blocked,
                                                    input logic [brss_pkg::DebWidth-1:0] ticks);
      brss_pkg::state_type r;
      r = d;
      if (blocked) begin
         if (r.debounce_count < ticks) begin
            r.debounce_count = r.debounce_count + 4'd1;
         end
         if (r.debounce_count >= ticks && r.edge_armed) begin
            r.trigger_flag = 1'b1;
            r.edge_armed   = 1'b0;
         end
      end else begin
         r.debounce_count = '0;
         r.edge_armed     = 1'b1;
      end
      return r;
   endfunction

   function automatic brss_pkg::state_type rearm(input brss_pkg::state_type d,
                                                 input logic blocked);
      brss_pkg::state_type r;
      r = d;
      r.edge_armed     = !blocked;
      r.debounce_count = '0;
      r.trigger_flag   = 1'b0;
      r.serve_lock     = 1'b0;
      r.phase          = brss_pkg::PH_PLAN;
      return r;
   endfunction

   always_comb begin
      for (int i = 0; i < brss_pkg::GateWidth; i++) begin
         gate_mask[i] = (i < GATE_COUNT);
      end
   end

   assign any      = |(item.gate_bits & gate_mask);
   assign ls_ext   = {item.left_speed[brss_pkg::SpeedWidth-1], item.left_speed};
   assign rs_ext   = {item.right_speed[brss_pkg::SpeedWidth-1], item.right_speed};
   assign ls_mag   = ls_ext[brss_pkg::SpeedWidth] ? 17'(-ls_ext) : 17'(ls_ext);
   assign rs_mag   = rs_ext[brss_pkg::SpeedWidth] ? 17'(-rs_ext) : 17'(rs_ext);
   assign stop_ext = {2'd0, cfg.stop_speed};
   assign wait_inc = state.wait_count + 10'd1;

   always_comb begin
      s    = state;
      kind = brss_pkg::KIND_NONE;
      case (state.phase)
         brss_pkg::PH_STARTUP: begin
            s.edge_armed     = !any;
            s.debounce_count = any ? cfg.debounce_ticks : '0;
            s.phase          = brss_pkg::PH_READY;
         end
         brss_pkg::PH_PLAN: begin
            s       = debounce(state, any, cfg.debounce_ticks);
            s.phase = brss_pkg::PH_READY;
         end
         brss_pkg::PH_STRIKE: begin
            kind = brss_pkg::KIND_STRIKE;
            if (item.left_angle <= cfg.left_limit && item.right_angle >= cfg.right_limit) begin
               s.captured_left  = item.left_angle;
               s.captured_right = item.right_angle;
               s.phase          = brss_pkg::PH_BRAKE;
            end
         end
         brss_pkg::PH_BRAKE: begin
            kind = brss_pkg::KIND_BRAKE;
            if (ls_mag < stop_ext && rs_mag < stop_ext) begin
               s.phase      = brss_pkg::PH_SETTLE;
               s.wait_count = '0;
            end
         end
         brss_pkg::PH_SETTLE: begin
            if (state.wait_count >= cfg.settle_ticks) begin
               kind         = brss_pkg::KIND_HOME;
               s.wait_count = '0;
               s.phase      = brss_pkg::PH_ALIGN;
               if (cfg.align_ticks == '0) begin
                  s = rearm(s, any);
               end
            end else begin
               s.wait_count = wait_inc;
            end
         end
         brss_pkg::PH_ALIGN: begin
            s.wait_count = wait_inc;
            if (wait_inc >= {2'd0, cfg.align_ticks}) begin
               s = rearm(s, any);
            end
         end
         default: begin
            s = debounce(state, any, cfg.debounce_ticks);
            if (s.trigger_flag && !s.serve_lock) begin
               s.serve_lock = 1'b1;
               s.phase      = brss_pkg::PH_STRIKE;
            end else begin
               s.phase = brss_pkg::PH_READY;
            end
         end
      endcase
   end

   assign state_next          = s;
   assign result.command_kind = kind;
   assign result.hold_left    = (kind == brss_pkg::KIND_BRAKE) ? s.captured_left : '0;
   assign result.hold_right   = (kind == brss_pkg::KIND_BRAKE) ? s.captured_right : '0;
   assign result.phase_now    = brss_pkg::phase_code(s.phase);
   assign result.trigger_seen = s.trigger_flag;
endmodule

FILE: rtl/ball_return_strike_sequencer.sv
// Ball return strike sequencer top level: tick input register, sequencer state,
// result register and the configuration bank. Depends on brss_pkg, brss_if,
// brss_csr and brss_step.
// A tick item is held in the input register and its result in the result register.
// Throughput: one tick item per cycle, stalled only while a result item waits unread.
// Reset: synchronous, active high; phase returns to startup, registers to defaults.
module ball_return_strike_sequencer #(
   parameter int GATE_COUNT = brss_pkg::DefaultGateCount
) (
   input  logic                           clock,
   input  logic                           reset,
   brss_req_if.sink                       req_ch,
   brss_rsp_if.source                     rsp_ch,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [brss_pkg::AddrWidth-1:0] paddr,
   input  logic [brss_pkg::DataWidth-1:0] pwdata,
   output logic [brss_pkg::DataWidth-1:0] prdata,
   output logic                           pready
);
   brss_pkg::cfg_type    cfg;
   brss_pkg::item_type   item_ff, item_in;
   logic                 in_valid_ff, in_valid_in;
   brss_pkg::state_type  state_ff, state_in;
   brss_pkg::result_type res_ff, res_in;
   logic                 out_valid_ff, out_valid_in;
   logic                 advance;
   logic                 accept;

   brss_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   brss_step #(.GATE_COUNT(GATE_COUNT)) u_step (
      .state      (state_ff),
      .item       (item_ff),
      .cfg        (cfg),
      .state_next (state_in),
      .result     (res_in)
   );

   assign advance      = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;
   assign accept       = req_ch.valid && req_ch.ready;

   assign item_in.gate_bits   = req_ch.gate_bits;
   assign item_in.left_angle  = req_ch.left_angle;
   assign item_in.right_angle = req_ch.right_angle;
   assign item_in.left_speed  = req_ch.left_speed;
   assign item_in.right_speed = req_ch.right_speed;

   assign in_valid_in  = accept || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '{phase: brss_pkg::PH_STARTUP, default: '0};
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= item_in;
      end
      if (advance) begin
         res_ff <= res_in;
      end
   end

   assign rsp_ch.valid        = out_valid_ff;
   assign rsp_ch.command_kind = res_ff.command_kind;
   assign rsp_ch.hold_left    = res_ff.hold_left;
   assign rsp_ch.hold_right   = res_ff.hold_right;
   assign rsp_ch.phase_now    = res_ff.phase_now;
   assign rsp_ch.trigger_seen = res_ff.trigger_seen;
endmodule

FILE: verif/strike_sequence_checker.sv
// Checker for the ball return strike sequencer: watches the tick, result and register ports,
// predicts every result item from its own copy of the sequencer state and compares fields.
// Depends on brss_pkg and the channel interfaces in brss_if.
module strike_sequence_checker
   import brss_pkg::*;
#(
   parameter int GATE_COUNT = DefaultGateCount
) (
   input  logic                 clock,
   input  logic                 reset,
   brss_req_if                  ticks,
   brss_rsp_if                  results,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [AddrWidth-1:0] paddr,
   input  logic [DataWidth-1:0] pwdata,
   input  logic                 pready,
   output int                   pending,
   output int                   failures
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [GateWidth-1:0] GateMask = GateWidth'((1 << GATE_COUNT) - 1);

   cfg_type                      cfg;
   logic signed [AngleWidth-1:0] left_home;
   logic signed [AngleWidth-1:0] right_home;

   logic [PhaseWidth-1:0]        seq_phase;
   logic [DebWidth-1:0]          deb_count;
   logic                         armed;
   logic                         trig;
   logic                         lock;
   logic signed [AngleWidth-1:0] hold_l;
   logic signed [AngleWidth-1:0] hold_r;
   logic [SettleWidth-1:0]       wait_count;

   result_type                   results_due[$];
   result_type                   want;
   item_type                     seen;
   int                           miss_count = 0;

   task automatic load_defaults();
      cfg.left_limit     = -16'sd1311;
      cfg.right_limit    = 16'sd1393;
      cfg.stop_speed     = 15'd1024;
      cfg.debounce_ticks = 4'd5;
      cfg.settle_ticks   = 10'd300;
      cfg.align_ticks    = 8'd40;
      left_home          = '0;
      right_home         = '0;
      seq_phase          = CODE_STARTUP;
      deb_count          = '0;
      armed              = 1'b0;
      trig               = 1'b0;
      lock               = 1'b0;
      hold_l             = '0;
      hold_r             = '0;
      wait_count         = '0;
   endtask

   task automatic count_gate(input logic blocked);
      if (blocked) begin
         if (deb_count < cfg.debounce_ticks) deb_count = deb_count + 1'b1;
         if (deb_count >= cfg.debounce_ticks && armed) begin
            trig  = 1'b1;
            armed = 1'b0;
         end
      end else begin
         deb_count = '0;
         armed     = 1'b1;
      end
   endtask

   task automatic rearm(input logic blocked);
      armed     = !blocked;
      deb_count = '0;
      trig      = 1'b0;
      lock      = 1'b0;
      seq_phase = CODE_PLAN;
   endtask

   task automatic predict_tick(input item_type t, output result_type r);
      logic     blocked;
      int       ls;
      int       rs;
      int       stop;
      kind_type kind;
      blocked = |(t.gate_bits & GateMask);
      ls      = $signed(t.left_speed);
      rs      = $signed(t.right_speed);
      stop    = int'(cfg.stop_speed);
      kind    = KIND_NONE;
      if (ls < 0) ls = -ls;
      if (rs < 0) rs = -rs;
      case (seq_phase)
         CODE_STARTUP: begin
            armed     = !blocked;
            deb_count = blocked ? cfg.debounce_ticks : '0;
            seq_phase = CODE_READY;
         end
         CODE_PLAN: begin
            count_gate(blocked);
            seq_phase = CODE_READY;
         end
         CODE_STRIKE: begin
            kind = KIND_STRIKE;
            if ($signed(t.left_angle) <= $signed(cfg.left_limit) &&
                $signed(t.right_angle) >= $signed(cfg.right_limit)) begin
               hold_l    = t.left_angle;
               hold_r    = t.right_angle;
               seq_phase = CODE_BRAKE;
            end
         end
         CODE_BRAKE: begin
            kind = KIND_BRAKE;
            if (ls < stop && rs < stop) begin
               seq_phase  = CODE_SETTLE;
               wait_count = '0;
            end
         end
         CODE_SETTLE: begin
            if (wait_count >= cfg.settle_ticks) begin
               kind       = KIND_HOME;
               wait_count = '0;
               seq_phase  = CODE_ALIGN;
               if (cfg.align_ticks == '0) rearm(blocked);
            end else begin
               wait_count = wait_count + 1'b1;
            end
         end
         CODE_ALIGN: begin
            wait_count = wait_count + 1'b1;
            if (wait_count >= {2'b00, cfg.align_ticks}) rearm(blocked);
         end
         default: begin
            count_gate(blocked);
            if (trig && !lock) begin
               lock      = 1'b1;
               seq_phase = CODE_STRIKE;
            end else begin
               seq_phase = CODE_READY;
            end
         end
      endcase
      r.command_kind = kind;
      r.hold_left    = (kind == KIND_BRAKE) ? hold_l : '0;
      r.hold_right   = (kind == KIND_BRAKE) ? hold_r : '0;
      r.phase_now    = seq_phase;
      r.trigger_seen = trig;
   endtask

   task automatic compare_field(input string name, input logic [15:0] exp_v, act_v);
      if (act_v !== exp_v) begin
         $error("%s: expected 'h%0h, got 'h%0h", name, exp_v, act_v);
         miss_count++;
      end
   endtask

   task automatic write_register(input logic [2:0] idx, input logic [DataWidth-1:0] data);
      case (reg_index_type'(idx))
         REG_LEFT_LIMIT:  cfg.left_limit     = data[AngleWidth-1:0];
         REG_RIGHT_LIMIT: cfg.right_limit    = data[AngleWidth-1:0];
         REG_STOP_SPEED:  cfg.stop_speed     = data[StopWidth-1:0];
         REG_DEBOUNCE:    cfg.debounce_ticks = data[DebWidth-1:0];
         REG_SETTLE:      cfg.settle_ticks   = data[SettleWidth-1:0];
         REG_ALIGN:       cfg.align_ticks    = data[AlignWidth-1:0];
         REG_LEFT_HOME:   left_home          = data[AngleWidth-1:0];
         REG_RIGHT_HOME:  right_home         = data[AngleWidth-1:0];
         default:         ;
      endcase
   endtask

   always @(posedge clock) begin
      if (reset) begin
         load_defaults();
         results_due.delete();
      end else begin
         if (results.valid && results.ready) begin
            if (results_due.size() == 0) begin
               $error("result item with no tick item waiting");
               miss_count++;
            end else begin
               want = results_due.pop_front();
               compare_field("command_kind", want.command_kind, results.command_kind);
               compare_field("hold_left", want.hold_left, results.hold_left);
               compare_field("hold_right", want.hold_right, results.hold_right);
               compare_field("phase_now", want.phase_now, results.phase_now);
               compare_field("trigger_seen", want.trigger_seen, results.trigger_seen);
            end
         end
         if (ticks.valid && ticks.ready) begin
            seen.gate_bits   = ticks.gate_bits;
            seen.left_angle  = ticks.left_angle;
            seen.right_angle = ticks.right_angle;
            seen.left_speed  = ticks.left_speed;
            seen.right_speed = ticks.right_speed;
            predict_tick(seen, want);
            results_due.push_back(want);
         end
         if (psel && penable && pwrite && pready) write_register(paddr[4:2], pwdata);
      end
      pending  <= results_due.size();
      failures <= miss_count;
   end

endmodule

FILE: verif/tb.sv
// Top of the strike sequencer testbench: clock, reset, register writes, tick stimulus,
// result back-pressure, watchdog and verdict. Depends on brss_pkg, brss_if, the RTL
// and strike_sequence_checker.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import brss_pkg::*;

   localparam int IdleLimit  = 2000;
   localparam int PhaseCount = 9;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 psel;
   logic                 penable;
   logic                 pwrite;
   logic [AddrWidth-1:0] paddr;
   logic [DataWidth-1:0] pwdata;
   logic [DataWidth-1:0] prdata;
   logic                 pready;

   brss_req_if tick_ch ();
   brss_rsp_if result_ch ();

   int pending;
   int failures;
   int idle_cycles = 0;
   int ticks_sent = 0;
   bit gaps_on = 1'b1;
   bit hold_results = 1'b0;

   int lim_left;
   int lim_right;
   int stop_mag;
   int deb_need;
   int settle_len;
   int align_len;

   ball_return_strike_sequencer uut (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (tick_ch),
      .rsp_ch  (result_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   strike_sequence_checker seq_check (
      .clock    (clock),
      .reset    (reset),
      .ticks    (tick_ch),
      .results  (result_ch),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .pready   (pready),
      .pending  (pending),
      .failures (failures)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      if (reset || psel || (tick_ch.valid && tick_ch.ready) ||
          (result_ch.valid && result_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
         $display("ball_return_strike_sequencer: mismatch");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      forever begin
         if (hold_results) begin
            result_ch.ready <= 1'b0;
            repeat (300) @(posedge clock);
            hold_results = 1'b0;
         end else if (gaps_on && $urandom_range(0, 7) == 0) begin
            result_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clock);
         end else begin
            result_ch.ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   function automatic int rand_between(input int lo, input int hi);
      return lo + int'($urandom_range(hi - lo, 0));
   endfunction

   function automatic int rnd16();
      return rand_between(-32768, 32767);
   endfunction

   function automatic int pick_speed(input bit slow);
      int m;
      if (slow) m = (stop_mag == 0) ? rand_between(0, 32768) : rand_between(0, stop_mag - 1);
      else m = rand_between(stop_mag, 32768);
      return $urandom_range(0, 1) ? -m : m;
   endfunction

   task automatic strike_angles(input bit pass, output int la, output int ra);
      la = rnd16();
      ra = rnd16();
      if (pass) begin
         la = ($urandom_range(0, 3) == 0) ? lim_left : rand_between(-32768, lim_left);
         ra = ($urandom_range(0, 3) == 0) ? lim_right : rand_between(lim_right, 32767);
      end else if (lim_left < 32767 && (lim_right == -32768 || $urandom_range(0, 1))) begin
         la = rand_between(lim_left + 1, 32767);
      end else if (lim_right > -32768) begin
         ra = rand_between(-32768, lim_right - 1);
      end
   endtask

   task automatic tick(input int gates, input int la, input int ra, input int ls, input int rs);
      if (gaps_on && $urandom_range(0, 7) == 0) begin
         tick_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      tick_ch.valid       <= 1'b1;
      tick_ch.gate_bits   <= gates[GateWidth-1:0];
      tick_ch.left_angle  <= la[AngleWidth-1:0];
      tick_ch.right_angle <= ra[AngleWidth-1:0];
      tick_ch.left_speed  <= ls[SpeedWidth-1:0];
      tick_ch.right_speed <= rs[SpeedWidth-1:0];
      do @(posedge clock); while (!tick_ch.ready);
      ticks_sent++;
   endtask

   task automatic drain();
      tick_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   task automatic write_register(input reg_index_type idx, input int value, input int width);
      logic [DataWidth-1:0] data;
      data = ($urandom() << width) | (DataWidth'(value) & ((32'd1 << width) - 1));
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic configure(input int l, input int r, input int s, input int d,
                            input int st, input int al, input int lh, input int rh);
      write_register(REG_LEFT_LIMIT, l, AngleWidth);
      write_register(REG_RIGHT_LIMIT, r, AngleWidth);
      write_register(REG_STOP_SPEED, s, StopWidth);
      write_register(REG_DEBOUNCE, d, DebWidth);
      write_register(REG_SETTLE, st, SettleWidth);
      write_register(REG_ALIGN, al, AlignWidth);
      write_register(REG_LEFT_HOME, lh, AngleWidth);
      write_register(REG_RIGHT_HOME, rh, AngleWidth);
      lim_left   = l;
      lim_right  = r;
      stop_mag   = s & 32'h7FFF;
      deb_need   = d & 32'hF;
      settle_len = st & 32'h3FF;
      align_len  = al & 32'hFF;
   endtask

   task automatic run_episode();
      int la;
      int ra;
      int tail;
      if ($urandom_range(0, 4) == 0) begin
         repeat ($urandom_range(3, 12))
            tick($urandom_range(0, 15), rnd16(), rnd16(), rnd16(), rnd16());
         return;
      end
      repeat ($urandom_range(1, 3)) tick(0, rnd16(), rnd16(), rnd16(), rnd16());
      // bounce: drop the gate before the count confirms it
      if (deb_need > 1 && $urandom_range(0, 3) == 0) begin
         repeat ($urandom_range(1, deb_need - 1))
            tick($urandom_range(1, 15), rnd16(), rnd16(), rnd16(), rnd16());
         tick(0, rnd16(), rnd16(), rnd16(), rnd16());
      end
      repeat ((deb_need == 0) ? 1 : deb_need + $urandom_range(0, 1)) begin
         strike_angles(1'b0, la, ra);
         tick($urandom_range(1, 15), la, ra, rnd16(), rnd16());
      end
      repeat ($urandom_range(0, 3)) begin
         strike_angles(1'b0, la, ra);
         tick($urandom_range(0, 15), la, ra, rnd16(), rnd16());
      end
      strike_angles(1'b1, la, ra);
      tick($urandom_range(0, 15), la, ra, rnd16(), rnd16());
      repeat ($urandom_range(0, 3))
         tick($urandom_range(0, 15), rnd16(), rnd16(), pick_speed(1'b0), rnd16());
      tick($urandom_range(0, 15), rnd16(), rnd16(), pick_speed(1'b1), pick_speed(1'b1));
      tail = settle_len + align_len + 1 + $urandom_range(0, 2);
      if (tail > 150) tail = 150;
      repeat (tail) tick($urandom_range(0, 15), rnd16(), rnd16(), rnd16(), rnd16());
   endtask

   initial begin
      int budget;
      int start;
      reset               <= 1'b1;
      psel                <= 1'b0;
      penable             <= 1'b0;
      pwrite              <= 1'b0;
      paddr               <= '0;
      pwdata              <= '0;
      tick_ch.valid       <= 1'b0;
      tick_ch.gate_bits   <= '0;
      tick_ch.left_angle  <= '0;
      tick_ch.right_angle <= '0;
      tick_ch.left_speed  <= '0;
      tick_ch.right_speed <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      configure(-100, 100, 500, 2, 2, 1, 16'h1234, -5);
      tick(15, 0, 0, 0, 0);
      tick(1, 0, 0, 0, 0);
      tick(0, 0, 0, 0, 0);
      tick(8, 0, 0, 0, 0);
      tick(8, 0, 0, 0, 0);
      tick(2, -100, 99, 0, 0);
      tick(0, -99, 100, 0, 0);
      tick(4, -100, 100, 32767, -32768);
      tick(0, 0, 0, -32768, 0);
      tick(0, 0, 0, 500, 0);
      tick(0, 0, 0, 499, -499);
      tick(0, 0, 0, 0, 0);
      tick(0, 0, 0, 0, 0);
      tick(15, 32767, -32768, 32767, -32768);
      tick(4, 0, 0, 0, 0);
      tick(4, 0, 0, 0, 0);
      tick(0, 0, 0, 0, 0);
      tick(1, 0, 0, 0, 0);
      tick(1, 0, 0, 0, 0);
      tick(0, -32768, 32767, 0, 0);
      tick(0, 0, 0, 0, 0);

      for (int p = 1; p < PhaseCount; p++) begin
         drain();
         case (p)
            1: configure(-1311, 1393, 1024, 5, 4, 3, 0, 0);
            2: configure(-2000, 2000, 2000, 0, 0, 0, 100, -100);
            3: configure(-32768, 32767, 32767, 15, 1023, 255, 32767, -32768);
            4: configure(32767, -32768, 0, 1, 0, 0, -1, 1);
            5: configure(rand_between(-3000, 0), rand_between(0, 3000), 1, rand_between(0, 15),
                         rand_between(0, 8), rand_between(0, 8), rnd16(), rnd16());
            PhaseCount - 1: configure(-500, 500, 800, 3, 6, 2, 0, 0);
            default: configure(rnd16(), rnd16(), rand_between(0, 32767), rand_between(0, 15),
                               rand_between(0, 12), rand_between(0, 12), rnd16(), rnd16());
         endcase
         if (p == 1) hold_results = 1'b1;
         if (p == PhaseCount - 1) gaps_on = 1'b0;
         budget = (p == 4) ? 60 : (p == 3) ? 150 : 280;
         start  = ticks_sent;
         while (ticks_sent - start < budget) run_episode();
      end

      drain();
      repeat (8) @(posedge clock);
      if (failures == 0) begin
         $display("ball_return_strike_sequencer: match");
      end else begin
         $display("ball_return_strike_sequencer: mismatch");
      end
      $finish;
   end

endmodule

FILE: sim.f
rtl/brss_pkg.sv
rtl/brss_if.sv
rtl/brss_csr.sv
rtl/brss_step.sv
rtl/ball_return_strike_sequencer.sv
verif/strike_sequence_checker.sv
verif/tb.sv
